// ----- src/swsr_pkg.sv -----
package swsr_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int ADDR_W     = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int POS_W      = 6;
   localparam int VAL_W      = 32;
   localparam int TOL_W      = 31;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_CMP,
      ST_ASC_RD,
      ST_ASC_CMP,
      ST_DESC_RD,
      ST_DESC_CMP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic query_init;
      logic search_rd;
      logic search_upd;
      logic walk_init;
      logic asc_rd;
      logic desc_rd;
      logic asc_inc;
      logic desc_dec;
      logic push;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic search_done;
      logic lt_upper;
      logic gt_lower;
      logic asc_end;
      logic desc_end;
   } status_type;

endpackage

// ----- src/swsr_ctrl.sv -----
module swsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_mode,
   input  swsr_pkg::status_type status,
   output swsr_pkg::cmd_type    cmd,
   output logic                 busy
);

   swsr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swsr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swsr_pkg::ST_IDLE: begin
            if (start && req_mode) begin
               state_in = status.empty ? swsr_pkg::ST_FINISH : swsr_pkg::ST_SEARCH;
            end
         end
         swsr_pkg::ST_SEARCH: begin
            state_in = status.search_done ? swsr_pkg::ST_ASC_RD : swsr_pkg::ST_SEARCH_CMP;
         end
         swsr_pkg::ST_SEARCH_CMP: begin
            state_in = (status.lt_upper && status.gt_lower) ? swsr_pkg::ST_ASC_RD
                                                            : swsr_pkg::ST_SEARCH;
         end
         swsr_pkg::ST_ASC_RD: begin
            state_in = status.asc_end ? swsr_pkg::ST_DESC_RD : swsr_pkg::ST_ASC_CMP;
         end
         swsr_pkg::ST_ASC_CMP: begin
            state_in = status.lt_upper ? swsr_pkg::ST_ASC_RD : swsr_pkg::ST_DESC_RD;
         end
         swsr_pkg::ST_DESC_RD: begin
            state_in = status.desc_end ? swsr_pkg::ST_FINISH : swsr_pkg::ST_DESC_CMP;
         end
         swsr_pkg::ST_DESC_CMP: begin
            state_in = status.gt_lower ? swsr_pkg::ST_DESC_RD : swsr_pkg::ST_FINISH;
         end
         swsr_pkg::ST_FINISH: begin
            state_in = swsr_pkg::ST_IDLE;
         end
         default: begin
            state_in = swsr_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         swsr_pkg::ST_IDLE: begin
            busy           = 1'b0;
            cmd.load       = start && !req_mode;
            cmd.query_init = start && req_mode;
         end
         swsr_pkg::ST_SEARCH: begin
            cmd.search_rd = !status.search_done;
            cmd.walk_init = status.search_done;
         end
         swsr_pkg::ST_SEARCH_CMP: begin
            if (status.lt_upper && status.gt_lower) begin
               cmd.walk_init = 1'b1;
            end else begin
               cmd.search_upd = 1'b1;
            end
         end
         swsr_pkg::ST_ASC_RD: begin
            cmd.asc_rd    = !status.asc_end;
            // end of list: back to mid + 1 for the downward walk
            cmd.walk_init = status.asc_end;
         end
         swsr_pkg::ST_ASC_CMP: begin
            if (status.lt_upper) begin
               cmd.push    = 1'b1;
               cmd.asc_inc = 1'b1;
            end else begin
               // restart the index at mid + 1 for the downward walk
               cmd.walk_init = 1'b1;
            end
         end
         swsr_pkg::ST_DESC_RD: begin
            cmd.desc_rd = !status.desc_end;
         end
         swsr_pkg::ST_DESC_CMP: begin
            cmd.push     = status.gt_lower;
            cmd.desc_dec = status.gt_lower;
         end
         swsr_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- src/swsr_dp.sv -----
module swsr_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  swsr_pkg::cmd_type                      cmd,
   input  logic                                   req_restart,
   input  logic signed [swsr_pkg::VAL_W-1:0]      req_element,
   input  logic signed [swsr_pkg::VAL_W-1:0]      req_probe,
   input  logic        [swsr_pkg::TOL_W-1:0]      req_tolerance,
   output swsr_pkg::status_type                   status,
   output logic                                   rsp_valid,
   output logic signed [swsr_pkg::VAL_W-1:0]      rsp_match_value,
   output logic        [swsr_pkg::POS_W-1:0]      rsp_match_position,
   output logic                                   rsp_none_found,
   output logic                                   rsp_last
);

   localparam int AW = swsr_pkg::ADDR_W;
   localparam int CW = swsr_pkg::CNT_W;
   localparam int VW = swsr_pkg::VAL_W;
   localparam int PW = swsr_pkg::POS_W;

   logic [VW-1:0] mem [swsr_pkg::LIST_DEPTH];

   logic [CW-1:0]        count_ff, count_in;
   logic signed [VW-1:0] probe_ff;
   logic signed [VW:0]   upper_ff, lower_ff;
   logic [AW-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [AW:0]          mid_sum;
   logic [AW-1:0]        mid;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic signed [VW-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr_ff;
   logic signed [VW:0]   data_ext;
   logic                 above_probe;

   logic                 pend_valid_ff, pend_valid_in;
   logic signed [VW-1:0] pend_value_ff;
   logic [AW-1:0]        pend_pos_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0] rsp_value_ff, rsp_value_in;
   logic [PW-1:0]        rsp_pos_ff, rsp_pos_in;
   logic                 rsp_none_ff, rsp_none_in;
   logic                 rsp_last_ff, rsp_last_in;

   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[AW:1];
   assign data_ext    = {rd_data_ff[VW-1], rd_data_ff};
   assign above_probe = rd_data_ff > probe_ff;

   always_comb begin
      status.empty       = count_ff == '0;
      status.search_done = (mid == lo_ff) || (mid == hi_ff);
      status.lt_upper    = data_ext < upper_ff;
      status.gt_lower    = data_ext > lower_ff;
      status.asc_end     = idx_ff >= count_ff;
      status.desc_end    = idx_ff == '0;
   end

   // single read port, address picked by the current command
   always_comb begin
      rd_en   = cmd.search_rd || cmd.asc_rd || cmd.desc_rd;
      rd_addr = mid;
      if (cmd.asc_rd) begin
         rd_addr = idx_ff[AW-1:0];
      end else if (cmd.desc_rd) begin
         rd_addr = AW'(idx_ff - CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (req_restart) begin
            mem[0] <= req_element;
         end else if (count_ff < CW'(swsr_pkg::LIST_DEPTH)) begin
            mem[count_ff[AW-1:0]] <= req_element;
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         if (req_restart) begin
            count_in = CW'(1);
         end else if (count_ff < CW'(swsr_pkg::LIST_DEPTH)) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      idx_in = idx_ff;
      if (cmd.query_init) begin
         lo_in = '0;
         hi_in = AW'(count_ff - CW'(1));
      end
      if (cmd.search_upd) begin
         if (above_probe) begin
            hi_in = rd_addr_ff;
         end else begin
            lo_in = rd_addr_ff;
         end
      end
      if (cmd.walk_init) begin
         idx_in = {{(CW-AW){1'b0}}, mid} + CW'(1);
      end else if (cmd.asc_inc) begin
         idx_in = idx_ff + CW'(1);
      end else if (cmd.desc_dec) begin
         idx_in = idx_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_init) begin
         probe_ff <= req_probe;
         upper_ff <= {req_probe[VW-1], req_probe} + $signed({2'b00, req_tolerance});
         lower_ff <= {req_probe[VW-1], req_probe} - $signed({2'b00, req_tolerance});
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
      if (cmd.push) begin
         pend_value_ff <= rd_data_ff;
         pend_pos_ff   <= rd_addr_ff;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // a match is held back one step so that the final one can carry last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = pend_value_ff;
      rsp_pos_in    = PW'(pend_pos_ff);
      rsp_none_in   = 1'b0;
      rsp_last_in   = 1'b0;
      if (cmd.query_init) begin
         pend_valid_in = 1'b0;
      end
      if (cmd.push) begin
         pend_valid_in = 1'b1;
         rsp_valid_in  = pend_valid_ff;
      end
      if (cmd.finish) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_last_in   = 1'b1;
         if (!pend_valid_ff) begin
            rsp_value_in = '0;
            rsp_pos_in   = '0;
            rsp_none_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_value    = rsp_value_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_none_found     = rsp_none_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff && rsp_last_ff)
      else $error("finish did not give a last transfer");

   a_push_not_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && pend_valid_ff) |=> rsp_valid_ff && !rsp_last_ff && !rsp_none_ff)
      else $error("held match not sent on push");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_none_ff) |-> (rsp_last_ff && rsp_value_ff == '0 && rsp_pos_ff == '0))
      else $error("none found transfer carries data");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(swsr_pkg::LIST_DEPTH))
      else $error("entry count above depth");
`endif

endmodule

// ----- src/sorted_window_search.sv -----
// sorted window search over an ascending list of signed q16.16 values
//
// input channel: a transfer happens at a rising edge with start high and busy low.
//   req_mode = 0 appends req_element to the list (req_restart = 1 empties it first);
//   loads beyond the list depth are dropped. busy stays low during a load.
//   req_mode = 1 runs a query with req_probe and req_tolerance.
// result channel: each result sits on the rsp_ ports for one cycle with rsp_valid high;
//   the receiver cannot stall, so results simply go out as they are found.
//   rsp_last marks the final result of a query; an empty list or an empty window
//   gives a single result with rsp_none_found high and zero value and position.
// timing: the list lives in a single-port memory with a registered read, so every
//   probed entry takes a read state and a compare state. a match goes out the cycle
//   after the next one is confirmed, the last one the cycle after the closing state.
//   busy is high from the accepting edge until the last result is on the rsp_ ports.
// reset: synchronous, active high; empties the list and drops any query in flight.
//   memory contents are not cleared, only entries below the count are ever read.
module sorted_window_search (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic                                 req_restart,
   input  logic signed [swsr_pkg::VAL_W-1:0]    req_element,
   input  logic signed [swsr_pkg::VAL_W-1:0]    req_probe,
   input  logic        [swsr_pkg::TOL_W-1:0]    req_tolerance,
   output logic                                 rsp_valid,
   output logic signed [swsr_pkg::VAL_W-1:0]    rsp_match_value,
   output logic        [swsr_pkg::POS_W-1:0]    rsp_match_position,
   output logic                                 rsp_none_found,
   output logic                                 rsp_last
);

   swsr_pkg::cmd_type    cmd;
   swsr_pkg::status_type status;

   // sequencer: search, upward walk, downward walk, closing transfer
   swsr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // list memory, search bounds, walk index and result staging
   swsr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_restart        (req_restart),
      .req_element        (req_element),
      .req_probe          (req_probe),
      .req_tolerance      (req_tolerance),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_match_value    (rsp_match_value),
      .rsp_match_position (rsp_match_position),
      .rsp_none_found     (rsp_none_found),
      .rsp_last           (rsp_last)
   );

endmodule
